// ===== design/wesfc_pkg.sv =====
// Shared constants and types for the wheel encoder sample filter and step counter.
`default_nettype none

package wesfc_pkg;

    // Window depth default and fixed field widths
    localparam int WINDOW_DEFAULT = 10;
    localparam int SAMPLE_W       = 12;
    localparam int SUM_W          = 16;
    localparam int HYST_W         = 8;
    localparam int SPT_W          = 8;
    localparam int COUNT_W        = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 12;
    localparam int QUEUE_DEPTH    = 2;

    // Configuration register reset values
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET  = 12'd1390;
    localparam logic [HYST_W-1:0]   HYSTERESIS_RESET = 8'd20;
    localparam logic [SPT_W-1:0]    SPT_RESET        = 8'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPT        = 2'd2;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

// ===== design/wesfc_front.sv =====
// Front part: accepts samples, updates the ring buffer and the running window sum.
`default_nettype none

module wesfc_front #(
    parameter int WINDOW = wesfc_pkg::WINDOW_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [wesfc_pkg::SAMPLE_W-1:0] sample,
    input  wire wesfc_pkg::q_stat_t            q_stat,
    output logic                               push,
    output logic [wesfc_pkg::SUM_W-1:0]        push_sum
);

    localparam int SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW - 1);

    logic [wesfc_pkg::SAMPLE_W-1:0] store_reg [WINDOW];
    logic [wesfc_pkg::SUM_W-1:0]    sum_reg;
    logic [wesfc_pkg::SUM_W-1:0]    sum_next;
    logic [SlotW-1:0]               slot_reg;
    logic [SlotW-1:0]               slot_next;
    logic                           accept;

    // Stall while the queue has no room
    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    // Replace the oldest sample in the running sum, wrapping at 16 bits
    assign sum_next  = sum_reg - wesfc_pkg::SUM_W'(store_reg[slot_reg])
                     + wesfc_pkg::SUM_W'(sample);
    assign slot_next = (slot_reg == LastSlot) ? '0 : slot_reg + 1'b1;

    assign push     = accept;
    assign push_sum = sum_next;

    // Hold the window, the sum and the write slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            slot_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            sum_reg             <= sum_next;
            slot_reg            <= slot_next;
            store_reg[slot_reg] <= sample;
        end
    end

endmodule

`default_nettype wire

// ===== design/wesfc_queue.sv =====
// Short queue of window sums between the front and back parts.
`default_nettype none

module wesfc_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [wesfc_pkg::SUM_W-1:0]   push_sum,
    input  wire logic                          pop,
    output logic [wesfc_pkg::SUM_W-1:0]        head_sum,
    output wesfc_pkg::q_stat_t                 q_stat
);

    localparam int PtrW = $clog2(wesfc_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(wesfc_pkg::QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] FullCount = CntW'(wesfc_pkg::QUEUE_DEPTH);
    localparam logic [PtrW-1:0] LastPtr   = PtrW'(wesfc_pkg::QUEUE_DEPTH - 1);

    logic [wesfc_pkg::SUM_W-1:0] entry_reg [wesfc_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]             wr_ptr_reg;
    logic [PtrW-1:0]             rd_ptr_reg;
    logic [CntW-1:0]             count_reg;
    logic [CntW-1:0]             count_next;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == FullCount);
    assign head_sum     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store pushed sums
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_sum;
        end
    end

endmodule

`default_nettype wire

// ===== design/wesfc_back.sv =====
// Back part: averages the window sum, runs the hysteresis comparator and the counters.
`default_nettype none

module wesfc_back #(
    parameter int WINDOW = wesfc_pkg::WINDOW_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire wesfc_pkg::q_stat_t               q_stat,
    input  wire logic [wesfc_pkg::SUM_W-1:0]      head_sum,
    output logic                                  pop,
    input  wire logic [wesfc_pkg::SAMPLE_W-1:0]   threshold,
    input  wire logic [wesfc_pkg::HYST_W-1:0]     hysteresis,
    input  wire logic [wesfc_pkg::SPT_W-1:0]      steps_per_turn,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [wesfc_pkg::SAMPLE_W-1:0]        filtered,
    output logic                                  rise_seen,
    output logic                                  step_counted,
    output logic [wesfc_pkg::COUNT_W-1:0]         step_total,
    output logic [wesfc_pkg::COUNT_W-1:0]         turn_total,
    output logic                                  indicator_on
);

    localparam int SW = wesfc_pkg::SAMPLE_W;
    localparam int CW = wesfc_pkg::COUNT_W;
    // Reciprocal multiply that is exact for every 16-bit sum
    localparam int ShiftK = wesfc_pkg::SUM_W + $clog2(WINDOW);
    localparam int RecipW = wesfc_pkg::SUM_W + 1;
    localparam int ProdW  = wesfc_pkg::SUM_W + RecipW;
    localparam logic [RecipW-1:0] Recip = RecipW'(((1 << ShiftK) + WINDOW - 1) / WINDOW);

    logic [ProdW-1:0]               prod;
    logic [SW-1:0]                  filt;
    logic [SW:0]                    upper;
    logic [SW-1:0]                  lower;
    logic                           rise;
    logic                           fall;
    logic [wesfc_pkg::SPT_W-1:0]    sit_inc;
    logic                           turn_done;

    logic                           valid_reg;
    logic [SW-1:0]                  prev_filt_reg;
    logic                           rise_reg;
    logic                           step_reg;
    logic                           armed_reg;
    logic [CW-1:0]                  step_count_reg;
    logic [wesfc_pkg::SPT_W-1:0]    sit_reg;
    logic [CW-1:0]                  turn_count_reg;
    logic                           ind_reg;

    // Take the next item when the output register is free or being drained
    assign pop = !q_stat.empty && (!valid_reg || !out_stall);

    // Floor of sum over window
    assign prod = ProdW'(head_sum) * ProdW'(Recip);
    assign filt = prod[ShiftK +: SW];

    // Comparator levels: upper without wrap, lower saturating at zero
    assign upper = {1'b0, threshold} + (SW + 1)'(hysteresis);
    assign lower = (threshold >= SW'(hysteresis)) ? threshold - SW'(hysteresis) : '0;

    assign rise = ({1'b0, prev_filt_reg} <= upper) && ({1'b0, filt} > upper);
    assign fall = armed_reg && (prev_filt_reg >= lower) && (filt < lower);

    assign sit_inc   = sit_reg + 1'b1;
    assign turn_done = (sit_inc >= steps_per_turn);

    // Hold comparator state, counters and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            prev_filt_reg  <= '0;
            rise_reg       <= 1'b0;
            step_reg       <= 1'b0;
            armed_reg      <= 1'b0;
            step_count_reg <= '0;
            sit_reg        <= '0;
            turn_count_reg <= '0;
            ind_reg        <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg     <= 1'b1;
                prev_filt_reg <= filt;
                rise_reg      <= rise;
                step_reg      <= fall;
                if (rise)
                begin
                    armed_reg <= 1'b1;
                end
                else if (fall)
                begin
                    armed_reg <= 1'b0;
                end
                if (fall)
                begin
                    step_count_reg <= step_count_reg + 1'b1;
                    if (turn_done)
                    begin
                        sit_reg        <= '0;
                        turn_count_reg <= turn_count_reg + 1'b1;
                        ind_reg        <= !ind_reg;
                    end
                    else
                    begin
                        sit_reg <= sit_inc;
                    end
                end
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = valid_reg;
    assign filtered     = prev_filt_reg;
    assign rise_seen    = rise_reg;
    assign step_counted = step_reg;
    assign step_total   = step_count_reg;
    assign turn_total   = turn_count_reg;
    assign indicator_on = ind_reg;

endmodule

`default_nettype wire

// ===== design/wheel_encoder_sample_filter_counter_unit.sv =====
// Top level of one wheel channel: configuration registers, front part, queue, back part.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one 12-bit sensor sample per item.
//   Output channel (out_valid / out_stall) returns one result item per sample:
//   the floored moving average over WINDOW samples, rise and step flags, the
//   step and turn totals, and the indicator level.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) set the
//   threshold, hysteresis and steps per turn; cfg_ready is always high, and
//   writes are to be made while no item is in flight; the block does not enforce this.
//   Data path: a sample accepted by the front updates the window, and the new
//   window sum is pushed into the queue; the back then averages and compares
//   it into the output register. Throughput: one item per cycle while the
//   receiver does not stall, set by the window read/write in the front and
//   the reciprocal multiply plus compare in the back.
//   Reset clears the window, sum, comparator state, counters and queue, and
//   loads the register defaults. While the receiver stalls, the output item
//   holds, the two-entry queue fills, and then in_stall rises.
`default_nettype none

module wheel_encoder_sample_filter_counter_unit #(
    parameter int WINDOW = wesfc_pkg::WINDOW_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [wesfc_pkg::SAMPLE_W-1:0]   sample,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [wesfc_pkg::SAMPLE_W-1:0]        filtered,
    output logic                                  rise_seen,
    output logic                                  step_counted,
    output logic [wesfc_pkg::COUNT_W-1:0]         step_total,
    output logic [wesfc_pkg::COUNT_W-1:0]         turn_total,
    output logic                                  indicator_on,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wesfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wesfc_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [wesfc_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [wesfc_pkg::HYST_W-1:0]   hysteresis_reg;
    logic [wesfc_pkg::SPT_W-1:0]    spt_reg;
    wesfc_pkg::q_stat_t             q_stat;
    logic                           push;
    logic                           pop;
    logic [wesfc_pkg::SUM_W-1:0]    push_sum;
    logic [wesfc_pkg::SUM_W-1:0]    head_sum;

    assign cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= wesfc_pkg::THRESHOLD_RESET;
            hysteresis_reg <= wesfc_pkg::HYSTERESIS_RESET;
            spt_reg        <= wesfc_pkg::SPT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wesfc_pkg::REG_THRESHOLD:  threshold_reg  <= cfg_data;
                wesfc_pkg::REG_HYSTERESIS: hysteresis_reg <= cfg_data[wesfc_pkg::HYST_W-1:0];
                wesfc_pkg::REG_SPT:        spt_reg        <= cfg_data[wesfc_pkg::SPT_W-1:0];
                default:                   ;
            endcase
        end
    end

    wesfc_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .q_stat   (q_stat),
        .push     (push),
        .push_sum (push_sum)
    );

    wesfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_sum (push_sum),
        .pop      (pop),
        .head_sum (head_sum),
        .q_stat   (q_stat)
    );

    wesfc_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .head_sum       (head_sum),
        .pop            (pop),
        .threshold      (threshold_reg),
        .hysteresis     (hysteresis_reg),
        .steps_per_turn (spt_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered       (filtered),
        .rise_seen      (rise_seen),
        .step_counted   (step_counted),
        .step_total     (step_total),
        .turn_total     (turn_total),
        .indicator_on   (indicator_on)
    );

endmodule

`default_nettype wire

// ===== design/wesfc_checker.sv =====
// Port-level checks for the wheel channel, bound to the top level.
`default_nettype none

module wesfc_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [wesfc_pkg::SAMPLE_W-1:0]   filtered,
    input  wire logic                             rise_seen,
    input  wire logic                             step_counted,
    input  wire logic [wesfc_pkg::COUNT_W-1:0]    step_total
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(filtered) && $stable(step_total))
        else $error("result changed while stalled");

    // Rise and step need opposite sides of the band
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(rise_seen && step_counted))
        else $error("rise and step on the same item");

    // A rise lies above some level, a step below some level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rise_seen || step_counted) |->
            (!rise_seen || filtered != '0) && (!step_counted || filtered != '1))
        else $error("crossing flag inconsistent with average");

endmodule

bind wheel_encoder_sample_filter_counter_unit wesfc_checker u_wesfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filtered     (filtered),
    .rise_seen    (rise_seen),
    .step_counted (step_counted),
    .step_total   (step_total)
);

`default_nettype wire
